>>> rtl/prrl_pkg.sv
package prrl_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned CountW  = 31;
  localparam int unsigned TotalW  = 32;
  localparam int unsigned IdxOutW = 10;
  localparam int unsigned EntryW  = CountW + 1;

  localparam logic [CountW-1:0] ThresholdReset = CountW'(10000);
  localparam logic [CountW-1:0] CountMax       = {CountW{1'b1}};
  localparam logic [TotalW-1:0] TotalMax       = {TotalW{1'b1}};

  localparam logic FuncPacket    = 1'b0;
  localparam logic FuncTick      = 1'b1;
  localparam logic VerdictPermit = 1'b0;
  localparam logic VerdictBlock  = 1'b1;

  typedef struct packed {
    logic mod_start;
    logic mem_read;
    logic update;
    logic report;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic clr_last;
    logic out_free;
  } status_t;

endpackage

>>> rtl/prrl_mod.sv
module prrl_mod #(
  parameter int unsigned NUM_RULES = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [prrl_pkg::KeyW-1:0]    key_i,
  output logic                         done_o,
  output logic [$clog2(NUM_RULES)-1:0] rem_o
);

  localparam int unsigned IdxW = $clog2(NUM_RULES);

  if ((1 << IdxW) == NUM_RULES) begin : g_pow2
    logic [IdxW-1:0] rem_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rem_q <= '0;
      end else if (start_i) begin
        rem_q <= key_i[IdxW-1:0];
      end
    end

    assign done_o = 1'b1;
    assign rem_o  = rem_q;
  end else begin : g_recip
    localparam int unsigned Shift = prrl_pkg::KeyW + IdxW;
    localparam int unsigned ProdW = 2 * prrl_pkg::KeyW + 1;
    localparam longint unsigned Recip = (64'd1 << Shift) / NUM_RULES;
    localparam logic [prrl_pkg::KeyW:0] RecipC = (prrl_pkg::KeyW + 1)'(Recip);
    localparam logic [IdxW:0] NumC = (IdxW + 1)'(NUM_RULES);

    logic [ProdW-1:0] prod;
    logic [IdxW:0]    quot_q;
    logic [IdxW:0]    key_lo_q;
    logic [IdxW:0]    diff;
    logic [IdxW-1:0]  rem_q;
    logic             busy_q;

    // quotient estimate is exact or one low, so one compare and subtract corrects it
    assign prod = ProdW'(key_i) * ProdW'(RecipC);
    assign diff = key_lo_q - quot_q * NumC;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
      end else begin
        busy_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        quot_q   <= prod[Shift +: IdxW + 1];
        key_lo_q <= key_i[IdxW:0];
      end
      if (busy_q) begin
        rem_q <= (diff >= NumC) ? diff[IdxW-1:0] - NumC[IdxW-1:0] : diff[IdxW-1:0];
      end
    end

    assign done_o = !busy_q;
    assign rem_o  = rem_q;
  end

endmodule

>>> rtl/prrl_ctrl.sv
module prrl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  prrl_pkg::status_t status_i,
  output prrl_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_UPDATE,
    ST_REPORT
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (func_i == prrl_pkg::FuncTick) begin
            state_d = ST_REPORT;
          end else begin
            cmd_o.mod_start = 1'b1;
            state_d         = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (status_i.mod_done) begin
          cmd_o.mem_read = 1'b1;
          state_d        = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (status_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (status_i.out_free) begin
          cmd_o.report = 1'b1;
          state_d      = ST_CLEAR;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/prrl_dp.sv
module prrl_dp #(
  parameter int unsigned NUM_RULES = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  prrl_pkg::cmd_t                  cmd_i,
  output prrl_pkg::status_t               status_o,
  input  logic                            cfg_we_i,
  input  logic [prrl_pkg::CountW-1:0]     cfg_wdata_i,
  input  logic [$clog2(NUM_RULES)-1:0]    idx_i,
  input  logic                            mod_done_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            is_report_o,
  output logic                            verdict_o,
  output logic [prrl_pkg::IdxOutW-1:0]    rule_index_o,
  output logic [prrl_pkg::CountW-1:0]     rule_permit_count_o,
  output logic [prrl_pkg::TotalW-1:0]     total_input_o,
  output logic [prrl_pkg::TotalW-1:0]     total_permit_o,
  output logic [prrl_pkg::TotalW-1:0]     total_block_o
);

  localparam int unsigned IdxW = $clog2(NUM_RULES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_RULES - 1);

  logic [prrl_pkg::EntryW-1:0] mem_q [NUM_RULES];
  logic [prrl_pkg::EntryW-1:0] rd_q;
  logic [prrl_pkg::EntryW-1:0] wr_data;
  logic [IdxW-1:0]             wr_addr;
  logic                        wr_en;

  logic [IdxW-1:0]             clr_cnt_q;
  logic [prrl_pkg::CountW-1:0] thr_q;
  logic [prrl_pkg::TotalW-1:0] sum_in_q;
  logic [prrl_pkg::TotalW-1:0] sum_permit_q;
  logic [prrl_pkg::TotalW-1:0] sum_block_q;
  logic                        out_valid_q;

  logic [prrl_pkg::CountW-1:0] cnt;
  logic [prrl_pkg::CountW-1:0] cnt_inc;
  logic [prrl_pkg::CountW-1:0] cnt_new;
  logic                        ctl;
  logic                        ctl_new;
  logic [IdxW+prrl_pkg::IdxOutW-1:0] idx_ext;

  assign cnt     = rd_q[prrl_pkg::CountW-1:0];
  assign ctl     = rd_q[prrl_pkg::CountW];
  assign cnt_inc = (cnt == prrl_pkg::CountMax) ? cnt : cnt + prrl_pkg::CountW'(1);
  assign cnt_new = ctl ? cnt : cnt_inc;
  assign ctl_new = ctl || (cnt_inc >= thr_q);
  assign idx_ext = (IdxW + prrl_pkg::IdxOutW)'(idx_i);

  assign wr_en   = cmd_i.clr_step || cmd_i.update;
  assign wr_addr = cmd_i.clr_step ? clr_cnt_q : idx_i;
  assign wr_data = cmd_i.clr_step ? '0 : {ctl_new, cnt_new};

  assign status_o.mod_done = mod_done_i;
  assign status_o.clr_last = (clr_cnt_q == LastIdx);
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.mem_read) begin
      rd_q <= mem_q[idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q    <= '0;
      thr_q        <= prrl_pkg::ThresholdReset;
      sum_in_q     <= '0;
      sum_permit_q <= '0;
      sum_block_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_step) begin
        clr_cnt_q <= (clr_cnt_q == LastIdx) ? '0 : clr_cnt_q + IdxW'(1);
      end
      if (cmd_i.update || cmd_i.report) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.report) begin
        sum_in_q     <= '0;
        sum_permit_q <= '0;
        sum_block_q  <= '0;
      end else if (cmd_i.update) begin
        if (sum_in_q != prrl_pkg::TotalMax) begin
          sum_in_q <= sum_in_q + prrl_pkg::TotalW'(1);
        end
        if (!ctl && (sum_permit_q != prrl_pkg::TotalMax)) begin
          sum_permit_q <= sum_permit_q + prrl_pkg::TotalW'(1);
        end
        if (ctl && (sum_block_q != prrl_pkg::TotalMax)) begin
          sum_block_q <= sum_block_q + prrl_pkg::TotalW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.report) begin
      is_report_o         <= 1'b1;
      verdict_o           <= prrl_pkg::VerdictPermit;
      rule_index_o        <= '0;
      rule_permit_count_o <= '0;
      total_input_o       <= sum_in_q;
      total_permit_o      <= sum_permit_q;
      total_block_o       <= sum_block_q;
    end else if (cmd_i.update) begin
      is_report_o         <= 1'b0;
      verdict_o           <= ctl ? prrl_pkg::VerdictBlock : prrl_pkg::VerdictPermit;
      rule_index_o        <= idx_ext[prrl_pkg::IdxOutW-1:0];
      rule_permit_count_o <= cnt_new;
      total_input_o       <= '0;
      total_permit_o      <= '0;
      total_block_o       <= '0;
    end
  end

endmodule

>>> rtl/per_rule_rate_limiter.sv
// Packet path: the input transfer starts the key remainder unit, the rule table is
// read, and the update loads the output register; for NUM_RULES not a power of two,
// the reciprocal key remainder unit adds a registered correction step. A packet is
// taken only once the last one is in the output register. A tick loads its report,
// then the rule table clear runs at one entry per cycle. A held output stalls the next
// input. Reset: totals zero, threshold 10000; the table clear runs with in_ready_o low.
module per_rule_rate_limiter #(
  parameter int unsigned NUM_RULES = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [prrl_pkg::CountW-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            func_i,
  input  logic [prrl_pkg::KeyW-1:0]       packet_key_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            is_report_o,
  output logic                            verdict_o,
  output logic [prrl_pkg::IdxOutW-1:0]    rule_index_o,
  output logic [prrl_pkg::CountW-1:0]     rule_permit_count_o,
  output logic [prrl_pkg::TotalW-1:0]     total_input_o,
  output logic [prrl_pkg::TotalW-1:0]     total_permit_o,
  output logic [prrl_pkg::TotalW-1:0]     total_block_o
);

  localparam int unsigned IdxW = $clog2(NUM_RULES);

  prrl_pkg::cmd_t    cmd;
  prrl_pkg::status_t status;
  logic              mod_done;
  logic [IdxW-1:0]   idx;

  prrl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  prrl_mod #(
    .NUM_RULES (NUM_RULES)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd.mod_start),
    .key_i   (packet_key_i),
    .done_o  (mod_done),
    .rem_o   (idx)
  );

  prrl_dp #(
    .NUM_RULES (NUM_RULES)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .idx_i               (idx),
    .mod_done_i          (mod_done),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .is_report_o         (is_report_o),
    .verdict_o           (verdict_o),
    .rule_index_o        (rule_index_o),
    .rule_permit_count_o (rule_permit_count_o),
    .total_input_o       (total_input_o),
    .total_permit_o      (total_permit_o),
    .total_block_o       (total_block_o)
  );

endmodule

>>> tb/tb_per_rule_rate_limiter.sv
module tb_per_rule_rate_limiter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRules    = 1024;
  localparam int unsigned NumPlanRows = 22;
  localparam int unsigned NumPhases   = 12;
  localparam int unsigned PhaseItems  = 150;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned DrainCycles = 40;
  localparam longint      LimitNs     = 3_000_000;

  typedef struct packed {
    logic                               is_report;
    logic                               verdict;
    logic [prrl_pkg::IdxOutW-1:0]       rule_index;
    logic [prrl_pkg::CountW-1:0]        permit_count;
    logic [prrl_pkg::TotalW-1:0]        total_input;
    logic [prrl_pkg::TotalW-1:0]        total_permit;
    logic [prrl_pkg::TotalW-1:0]        total_block;
  } limit_result_t;

  typedef enum logic [1:0] {
    RowPacket,
    RowTick,
    RowThreshold
  } row_kind_e;

  typedef struct {
    row_kind_e     kind;
    logic [31:0]   value;
    logic          typed;
    limit_result_t want;
  } stim_row_t;

  logic                               clk_i               = 1'b0;
  logic                               rst_ni              = 1'b0;
  logic                               cfg_we_i            = 1'b0;
  logic [prrl_pkg::CountW-1:0]        cfg_wdata_i         = '0;
  logic                               in_valid_i          = 1'b0;
  logic                               in_ready_o;
  logic                               func_i              = prrl_pkg::FuncPacket;
  logic [prrl_pkg::KeyW-1:0]          packet_key_i        = '0;
  logic                               out_valid_o;
  logic                               out_ready_i         = 1'b0;
  logic                               is_report_o;
  logic                               verdict_o;
  logic [prrl_pkg::IdxOutW-1:0]       rule_index_o;
  logic [prrl_pkg::CountW-1:0]        rule_permit_count_o;
  logic [prrl_pkg::TotalW-1:0]        total_input_o;
  logic [prrl_pkg::TotalW-1:0]        total_permit_o;
  logic [prrl_pkg::TotalW-1:0]        total_block_o;

  per_rule_rate_limiter #(
    .NUM_RULES(NumRules)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .func_i             (func_i),
    .packet_key_i       (packet_key_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .is_report_o        (is_report_o),
    .verdict_o          (verdict_o),
    .rule_index_o       (rule_index_o),
    .rule_permit_count_o(rule_permit_count_o),
    .total_input_o      (total_input_o),
    .total_permit_o     (total_permit_o),
    .total_block_o      (total_block_o)
  );

  always #2 clk_i = ~clk_i;

  // Shadow state of the limiter
  logic [prrl_pkg::CountW-1:0] rule_permit_cnt [NumRules];
  logic                        rule_blocking   [NumRules];
  logic [prrl_pkg::TotalW-1:0] period_inputs  = '0;
  logic [prrl_pkg::TotalW-1:0] period_permits = '0;
  logic [prrl_pkg::TotalW-1:0] period_blocks  = '0;
  logic [prrl_pkg::CountW-1:0] cur_threshold  = prrl_pkg::ThresholdReset;

  limit_result_t pending_results [$];
  int unsigned   mismatch_count  = 0;

  int unsigned send_idle_pct = 10;
  int unsigned sink_idle_pct = 5;
  bit          quiet_tail    = 1'b0;
  bit          hold_req      = 1'b0;

  initial begin
    for (int i = 0; i < NumRules; i++) begin
      rule_permit_cnt[i] = '0;
      rule_blocking[i]   = 1'b0;
    end
  end

  function automatic limit_result_t limit_verdict(logic f, logic [prrl_pkg::KeyW-1:0] k);
    limit_result_t               r;
    int unsigned                 idx;
    logic [prrl_pkg::CountW-1:0] cnt;
    r = '0;
    if (f == prrl_pkg::FuncTick) begin
      r.is_report    = 1'b1;
      r.total_input  = period_inputs;
      r.total_permit = period_permits;
      r.total_block  = period_blocks;
      period_inputs  = '0;
      period_permits = '0;
      period_blocks  = '0;
      for (int i = 0; i < NumRules; i++) begin
        rule_permit_cnt[i] = '0;
        rule_blocking[i]   = 1'b0;
      end
      return r;
    end
    idx = k % NumRules;
    if (period_inputs != prrl_pkg::TotalMax) period_inputs++;
    cnt = rule_permit_cnt[idx];
    if (!rule_blocking[idx]) begin
      if (cnt != prrl_pkg::CountMax) cnt++;
      rule_permit_cnt[idx] = cnt;
      if (period_permits != prrl_pkg::TotalMax) period_permits++;
      if (cnt >= cur_threshold) rule_blocking[idx] = 1'b1;
      r.verdict = prrl_pkg::VerdictPermit;
    end else begin
      if (period_blocks != prrl_pkg::TotalMax) period_blocks++;
      r.verdict = prrl_pkg::VerdictBlock;
    end
    r.rule_index   = prrl_pkg::IdxOutW'(idx);
    r.permit_count = cnt;
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic int unsigned next_gap();
    if (quiet_tail || $urandom_range(0, 99) >= send_idle_pct) return 0;
    return $urandom_range(1, 18);
  endfunction

  // Leaves valid high on return; the caller lowers it or offers the next item
  task automatic send_item(logic f, logic [prrl_pkg::KeyW-1:0] k, int unsigned gap,
                           logic typed, limit_result_t want);
    limit_result_t pred;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    packet_key_i <= k;
    do @(posedge clk_i); while (!in_ready_o);
    pred = limit_verdict(f, k);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_threshold(logic [prrl_pkg::CountW-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    cur_threshold  = v;
  endtask

  stim_row_t plan [NumPlanRows] = '{
    '{RowTick,      32'h0,         1'b1,
      '{1'b1, prrl_pkg::VerdictPermit, 10'd0, 31'd0, 32'd0, 32'd0, 32'd0}},
    '{RowPacket,    32'h0,         1'b1,
      '{1'b0, prrl_pkg::VerdictPermit, 10'd0, 31'd1, 32'd0, 32'd0, 32'd0}},
    '{RowPacket,    32'hFFFF_FFFF, 1'b1,
      '{1'b0, prrl_pkg::VerdictPermit, 10'd1023, 31'd1, 32'd0, 32'd0, 32'd0}},
    '{RowPacket,    32'h0000_0400, 1'b1,
      '{1'b0, prrl_pkg::VerdictPermit, 10'd0, 31'd2, 32'd0, 32'd0, 32'd0}},
    '{RowTick,      32'h0,         1'b1,
      '{1'b1, prrl_pkg::VerdictPermit, 10'd0, 31'd0, 32'd3, 32'd3, 32'd0}},
    '{RowThreshold, 32'h0,         1'b0, '0},
    '{RowPacket,    32'h0000_0005, 1'b0, '0},
    '{RowPacket,    32'h0000_0005, 1'b0, '0},
    '{RowPacket,    32'h8000_0005, 1'b0, '0},
    '{RowPacket,    32'h0000_03FF, 1'b0, '0},
    '{RowThreshold, 32'h2,         1'b0, '0},
    '{RowPacket,    32'h0000_0006, 1'b0, '0},
    '{RowPacket,    32'h0000_0006, 1'b0, '0},
    '{RowPacket,    32'h0000_0006, 1'b0, '0},
    '{RowPacket,    32'h0000_0005, 1'b0, '0},
    '{RowThreshold, 32'h7FFF_FFFF, 1'b0, '0},
    '{RowPacket,    32'h5555_5555, 1'b0, '0},
    '{RowPacket,    32'hAAAA_AAAA, 1'b0, '0},
    '{RowPacket,    32'h0000_0007, 1'b0, '0},
    '{RowTick,      32'h0,         1'b0, '0},
    '{RowPacket,    32'h0000_0005, 1'b0, '0},
    '{RowTick,      32'h0,         1'b0, '0}
  };

  initial begin : driver
    logic [prrl_pkg::IdxOutW-1:0] hot_rules [6];
    int unsigned                  hot_count;
    int unsigned                  tick_permille;
    logic [prrl_pkg::CountW-1:0]  thr;
    logic [prrl_pkg::KeyW-1:0]    key;
    logic                         f;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[r]) begin
      case (plan[r].kind)
        RowThreshold: set_threshold(prrl_pkg::CountW'(plan[r].value));
        RowTick:      send_item(prrl_pkg::FuncTick, '0, next_gap(), plan[r].typed,
                                plan[r].want);
        default:      send_item(prrl_pkg::FuncPacket, plan[r].value, next_gap(),
                                plan[r].typed, plan[r].want);
      endcase
    end

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       thr = '0;
        1:       thr = prrl_pkg::CountMax;
        2:       thr = prrl_pkg::CountW'(1);
        3:       thr = prrl_pkg::ThresholdReset;
        default: begin
          case ($urandom_range(0, 5))
            0:       thr = prrl_pkg::CountW'($urandom);
            5:       thr = prrl_pkg::CountW'($urandom_range(13, 80));
            default: thr = prrl_pkg::CountW'($urandom_range(1, 12));
          endcase
        end
      endcase
      set_threshold(thr);
      quiet_tail    = (p >= NumPhases - 2);
      send_idle_pct = quiet_tail ? 0 : $urandom_range(0, 2) * 10;
      sink_idle_pct = quiet_tail ? 0 : $urandom_range(0, 3) * 5;
      case ($urandom_range(0, 2))
        0:       tick_permille = 0;
        1:       tick_permille = 10;
        default: tick_permille = 30;
      endcase
      hot_count = $urandom_range(1, 6);
      foreach (hot_rules[h]) hot_rules[h] = prrl_pkg::IdxOutW'($urandom);

      for (int i = 0; i < PhaseItems; i++) begin
        if (!quiet_tail && (p == 2 || p == 6) && i == 40) hold_req = 1'b1;
        key = $urandom;
        f   = prrl_pkg::FuncPacket;
        if ($urandom_range(0, 999) < tick_permille) begin
          f = prrl_pkg::FuncTick;
        end else if ($urandom_range(0, 9) < 8) begin
          key[prrl_pkg::IdxOutW-1:0] = hot_rules[$urandom_range(0, hot_count - 1)];
        end
        send_item(f, key, next_gap(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : sink
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (!quiet_tail && $urandom_range(0, 99) < sink_idle_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    limit_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected transfer", 32'(is_report_o), 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (is_report_o !== want.is_report)
          flag_mismatch("is_report", 32'(is_report_o), 32'(want.is_report));
        if (verdict_o !== want.verdict)
          flag_mismatch("verdict", 32'(verdict_o), 32'(want.verdict));
        if (rule_index_o !== want.rule_index)
          flag_mismatch("rule_index", 32'(rule_index_o), 32'(want.rule_index));
        if (rule_permit_count_o !== want.permit_count)
          flag_mismatch("rule_permit_count", 32'(rule_permit_count_o),
                        32'(want.permit_count));
        if (total_input_o !== want.total_input)
          flag_mismatch("total_input", total_input_o, want.total_input);
        if (total_permit_o !== want.total_permit)
          flag_mismatch("total_permit", total_permit_o, want.total_permit);
        if (total_block_o !== want.total_block)
          flag_mismatch("total_block", total_block_o, want.total_block);
      end
    end
  end

  initial begin : watchdog
    #(LimitNs);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
